@@ hdl/esc_rle_pkg.sv @@
`default_nettype none

package esc_rle_pkg;

    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

    // parser phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_VAL  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] run_length;
        logic        image_done;
    } t_out_item;

endpackage

`default_nettype wire

@@ hdl/escape_rle_byte_decoder.sv @@
// An accepted item waits in the input register, is parsed there, and its runs
// go into the run buffer, from which the first is offered on the output.
// Throughput: one item per cycle while each item yields at most one run and the
// output does not stall; an item that yields more runs holds the input until the
// three-slot run buffer, draining one run per unstalled cycle, has emptied.
// Reset (synchronous, active low) clears the parser, pixel count, register and
// all valid flags; no clearing pass is needed.
`default_nettype none

module escape_rle_byte_decoder #(
    parameter int unsigned MAX_PIXELS = 65535
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // compressed byte channel
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  esc_rle_pkg::t_in_item   i_in_item,
    // run descriptor channel
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output esc_rle_pkg::t_out_item  o_out_item,
    // expected pixel count register
    input  wire                     i_cfg_we,
    input  wire  [15:0]             i_cfg_data
);
    import esc_rle_pkg::*;

    // The pixel count lives in 16 bits, so a cap above that never bites.
    localparam int unsigned CAP_I = (MAX_PIXELS > 65535) ? 65535 : MAX_PIXELS;
    localparam logic [15:0] CAP   = 16'(CAP_I);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [15:0] r_expected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (i_cfg_we) begin
            r_expected <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one item until the run buffer can take its runs
    // ------------------------------------------------------------------
    logic       r_iv;
    t_in_item   r_in;
    logic       in_take;
    logic       load;

    // ------------------------------------------------------------------
    // Run buffer: three slots, drained oldest first
    // ------------------------------------------------------------------
    t_out_item  r_slot [3];
    logic [2:0] r_vld;
    logic [2:0] pick;
    logic [2:0] take_mask;
    logic [2:0] vld_left;

    // Parser state
    logic [1:0]  r_phase;
    logic [7:0]  r_held;
    logic [15:0] r_emitted;

    // Pick the lowest valid slot; slots fill in stream order.
    always_comb begin
        pick = 3'b000;
        if (r_vld[0]) begin
            pick = 3'b001;
        end else if (r_vld[1]) begin
            pick = 3'b010;
        end else if (r_vld[2]) begin
            pick = 3'b100;
        end
    end

    always_comb begin
        o_out_valid = |r_vld;
        o_out_item  = r_slot[2];
        if (pick[0]) begin
            o_out_item = r_slot[0];
        end else if (pick[1]) begin
            o_out_item = r_slot[1];
        end
    end

    assign take_mask  = (o_out_valid && !i_out_stall) ? pick : 3'b000;
    assign vld_left   = r_vld & ~take_mask;
    // Move the held item into the buffer once the buffer empties this cycle.
    assign load       = r_iv && (vld_left == 3'b000);
    assign o_in_stall = r_iv && !load;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (in_take) begin
            r_iv <= 1'b1;
        end else if (load) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
    end

    // ------------------------------------------------------------------
    // Parse and clip: up to two data runs and one zero pad per item
    // ------------------------------------------------------------------
    logic [15:0] target;
    logic        full;
    logic [15:0] room0;
    logic        fin;
    logic [7:0]  b;

    logic        c1_en;
    logic [7:0]  c1_val;
    logic [15:0] c1_len;
    logic        c2_en;
    logic [1:0]  n_phase;
    logic [7:0]  n_held;

    logic        e1, e2, e3;
    logic [15:0] len1, len3;
    logic [15:0] room1, room2;
    logic [15:0] n_emitted;

    assign target = (r_expected > CAP) ? CAP : r_expected;
    assign full   = (r_emitted >= target);
    // A full image leaves no room, which silences every run below.
    assign room0  = full ? 16'd0 : (target - r_emitted);
    assign fin    = r_in.final_byte;
    assign b      = r_in.data_byte;

    always_comb begin
        c1_en   = 1'b0;
        c1_val  = b;
        c1_len  = 16'd1;
        c2_en   = 1'b0;
        n_phase = r_phase;
        n_held  = r_held;
        if (!full) begin
            case (r_phase)
                PH_ESC: begin
                    if (fin) begin
                        // escape cut short: both bytes go out as literals
                        c1_en   = 1'b1;
                        c1_val  = ESCAPE_BYTE;
                        c2_en   = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_held  = b;
                        n_phase = PH_VAL;
                    end
                end
                PH_VAL: begin
                    c1_en   = 1'b1;
                    c1_val  = r_held;
                    c1_len  = (b == 8'd0) ? 16'd1 : {8'd0, b};
                    n_phase = PH_IDLE;
                end
                default: begin
                    if (b == ESCAPE_BYTE && !fin) begin
                        n_phase = PH_ESC;
                    end else begin
                        c1_en   = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        e1    = c1_en && (room0 != 16'd0);
        len1  = (c1_len > room0) ? room0 : c1_len;
        room1 = e1 ? (room0 - len1) : room0;
        e2    = c2_en && (room1 != 16'd0);
        room2 = e2 ? (room1 - 16'd1) : room1;
        // pad the rest of the image with zeros on the last byte
        e3    = fin && (room2 != 16'd0);
        len3  = room2;
        n_emitted = target - room2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 3'b000;
            r_phase   <= PH_IDLE;
            r_held    <= '0;
            r_emitted <= '0;
        end else if (load) begin
            r_vld <= {e3, e2, e1};
            if (fin) begin
                // end of stream: start the next one from scratch
                r_phase   <= PH_IDLE;
                r_held    <= '0;
                r_emitted <= '0;
            end else begin
                r_phase <= n_phase;
                r_held  <= n_held;
                if (!full) begin
                    r_emitted <= n_emitted;
                end
            end
        end else begin
            r_vld <= vld_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot[0] <= '{pixel_value: c1_val, run_length: len1,
                           image_done: (room1 == 16'd0)};
            r_slot[1] <= '{pixel_value: b, run_length: 16'd1,
                           image_done: (room2 == 16'd0)};
            r_slot[2] <= '{pixel_value: 8'd0, run_length: len3,
                           image_done: 1'b1};
        end
    end

endmodule

`default_nettype wire

@@ hdl/esc_rle_chk.sv @@
`default_nettype none

module esc_rle_chk (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_valid,
    input wire                    o_in_stall,
    input esc_rle_pkg::t_in_item  i_in_item,
    input wire                    o_out_valid,
    input wire                    i_out_stall,
    input esc_rle_pkg::t_out_item o_out_item
);
    import esc_rle_pkg::*;

    // A stalled run holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled run changed or dropped");

    // A stalled input item holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_item)))
        else $error("stalled input item changed or dropped");

    // Runs are never empty.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.run_length != 16'd0))
        else $error("run of length zero");

    // Reset leaves no run pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("run visible after reset");

    // With the run buffer empty the input never stalls.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

endmodule

bind escape_rle_byte_decoder esc_rle_chk u_esc_rle_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

@@ tb/sv/escape_rle_byte_decoder_test.sv @@
`timescale 1ns / 100ps

module escape_rle_byte_decoder_test;
    import esc_rle_pkg::*;

    localparam int unsigned MAX_PIXELS     = 65535;  // matches the default of the instance
    localparam int          ITEM_GOAL      = 250;
    localparam int          SETTLE_CYCLES  = 8;      // covers accept-to-show plus buffer drain
    localparam int          WATCHDOG_LIMIT = 2000;

    // one queued compressed byte; wait_drain holds it back until every run has come
    typedef struct packed {
        t_in_item item;
        logic     wait_drain;
    } t_feed;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = '0;
    wire         in_stall;
    wire         out_valid;
    t_out_item   out_item;

    escape_rle_byte_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // pending compressed bytes and the runs they are predicted to produce
    t_feed       byte_feed[$];
    t_out_item   pending_runs[$];

    // decoder state as predicted from the accepted items
    logic [15:0] pixel_target = '0;
    logic [1:0]  parse_ph     = PH_IDLE;
    logic [7:0]  held_pix     = '0;
    int unsigned pix_count    = 0;

    int send_idle_pct = 26;
    int recv_idle_pct = 52;
    int errors        = 0;
    int queued_items  = 0;
    int bytes_sent    = 0;
    int streams_done  = 0;
    int runs_checked  = 0;
    int pad_runs      = 0;
    int ignored_bytes = 0;
    int cfg_writes    = 0;
    int quiet_cycles  = 0;

    // ------------------------------------------------------------------
    // Run prediction
    // ------------------------------------------------------------------

    // Effective image size: the register, capped by the build limit.
    function automatic int unsigned image_size();
        return (pixel_target > MAX_PIXELS) ? MAX_PIXELS : int'(pixel_target);
    endfunction

    // Clip a run to the room left in the image and queue it; drop it if full.
    function automatic void push_run(logic [7:0] value, int unsigned len);
        int unsigned room;
        t_out_item   run;
        if (pix_count >= image_size() || len == 0)
            return;
        room = image_size() - pix_count;
        if (len > room)
            len = room;
        pix_count       += len;
        run.pixel_value  = value;
        run.run_length   = len[15:0];
        run.image_done   = (pix_count == image_size());
        pending_runs.insert(pending_runs.size(), run);
    endfunction

    // Advance the parser by one accepted byte and queue the runs it yields.
    function automatic void decode_byte(t_in_item it);
        if (pix_count < image_size()) begin
            case (parse_ph)
                PH_ESC: begin
                    if (it.final_byte) begin
                        // escape cut short after its value: both bytes become literals
                        push_run(ESCAPE_BYTE, 1);
                        push_run(it.data_byte, 1);
                        parse_ph = PH_IDLE;
                    end else begin
                        held_pix = it.data_byte;
                        parse_ph = PH_VAL;
                    end
                end
                PH_VAL: begin
                    // a zero count still means one pixel
                    push_run(held_pix, (it.data_byte == 8'd0) ? 1 : int'(it.data_byte));
                    parse_ph = PH_IDLE;
                end
                default: begin
                    // an escape as the last byte falls through as a literal
                    if (it.data_byte == ESCAPE_BYTE && !it.final_byte) begin
                        parse_ph = PH_ESC;
                    end else begin
                        push_run(it.data_byte, 1);
                        parse_ph = PH_IDLE;
                    end
                end
            endcase
        end else begin
            ignored_bytes++;
        end
        if (it.final_byte) begin
            // pad the rest of the image with zeros, then start over
            if (pix_count < image_size()) begin
                push_run(8'd0, image_size() - pix_count);
                pad_runs++;
            end
            parse_ph  = PH_IDLE;
            held_pix  = '0;
            pix_count = 0;
            streams_done++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued items, predict on every accepted one
    // ------------------------------------------------------------------
    always @(posedge clk) begin : drive_bytes
        logic  take;
        t_feed nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_byte(in_item);
                bytes_sent++;
            end
            // advance only when nothing is held on the bus
            if (!in_valid || !in_stall) begin
                take = 1'b0;
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    // hold a marked item until every predicted run has arrived
                    take = !(byte_feed[0].wait_drain && pending_runs.size() != 0);
                end
                if (take) begin
                    nxt      = byte_feed.pop_front();
                    in_valid <= 1'b1;
                    in_item  <= nxt.item;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted run with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: run %0d %s expected %0d got %0d", $time, runs_checked, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin : watch_runs
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_runs.size() == 0) begin
                    $display("%0t: unexpected run expected none got value %0d length %0d done %0d",
                             $time, out_item.pixel_value, out_item.run_length,
                             out_item.image_done);
                    errors++;
                end else begin
                    want = pending_runs.pop_front();
                    check_field("pixel_value", want.pixel_value, out_item.pixel_value);
                    check_field("run_length", want.run_length, out_item.run_length);
                    check_field("image_done", want.image_done, out_item.image_done);
                    runs_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run when neither channel has moved for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] data, logic last, logic hold);
        t_feed f;
        f.item.data_byte  = data;
        f.item.final_byte = last;
        f.wait_drain      = hold;
        byte_feed.insert(byte_feed.size(), f);
        queued_items++;
    endfunction

    function automatic void add_escape(logic [7:0] value, logic [7:0] count, logic last);
        add_byte(ESCAPE_BYTE, 1'b0, 1'b0);
        add_byte(value, 1'b0, 1'b0);
        add_byte(count, last, 1'b0);
    endfunction

    task automatic wait_feed_empty();
        while (byte_feed.size() != 0)
            @(posedge clk);
    endtask

    // Wait until every item is accepted and every run has come, then let the
    // pipeline settle, since some items leave no run behind.
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (byte_feed.size() != 0 || in_valid || pending_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pixel_target(logic [15:0] value);
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        pixel_target  = value;
        cfg_writes++;
    endtask

    // Mostly small images so they fill up; a few empty, full-size or anywhere.
    function automatic logic [15:0] random_target();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return 16'd0;
        if (r < 16) return 16'hFFFF;
        if (r < 56) return 16'($urandom_range(40, 1));
        if (r < 86) return 16'($urandom_range(1500, 41));
        return 16'($urandom_range(65535));
    endfunction

    function automatic logic [7:0] random_count();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 8'd0;
        if (r < 30) return 8'($urandom_range(255, 128));
        return 8'($urandom_range(20, 1));
    endfunction

    // One well-formed stream with random content, a little noise, and a
    // random ending that may cut an escape short.
    task automatic build_stream();
        int segs;
        int split_at;
        int r;
        segs     = $urandom_range(12, 1);
        split_at = ($urandom_range(99) < 12) ? $urandom_range(segs - 1) : -1;
        for (int i = 0; i < segs; i++) begin
            // retarget in the middle of a stream, possibly below what is out
            if (i == split_at)
                write_pixel_target(random_target());
            r = $urandom_range(99);
            if (r < 45)
                add_byte(8'($urandom_range(254)), 1'b0, $urandom_range(99) < 4);
            else if (r < 85)
                add_escape(8'($urandom_range(255)), random_count(), 1'b0);
            else if (r < 95)
                add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            else
                add_byte(8'($urandom_range(255)), 1'b1, 1'b0);  // stray end mark
        end
        r = $urandom_range(99);
        if (r < 50) begin
            add_byte(8'($urandom_range(255)), 1'b1, 1'b0);
        end else if (r < 65) begin
            add_byte(ESCAPE_BYTE, 1'b1, 1'b0);
        end else if (r < 80) begin
            add_byte(ESCAPE_BYTE, 1'b0, 1'b0);
            add_byte(8'($urandom_range(255)), 1'b1, 1'b0);
        end else begin
            add_escape(8'($urandom_range(255)), random_count(), 1'b1);
        end
    endtask

    initial begin
        int idle_mode;
        idle_mode = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty image: nothing may come out, escapes and end mark included.
        write_pixel_target(16'd0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(ESCAPE_BYTE, 1'b0, 1'b0);
        add_byte(8'h5A, 1'b1, 1'b0);

        // Small image: literals, a zero count, a run clipped at the edge,
        // then bytes that arrive after the image is full.
        write_pixel_target(16'd20);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFE, 1'b0, 1'b0);
        add_escape(8'h80, 8'h00, 1'b0);
        add_escape(8'h7F, 8'hFF, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);

        // Largest image: escapes cut short by the end mark, an escaped
        // escape value, and long zero pads.
        write_pixel_target(16'hFFFF);
        add_byte(ESCAPE_BYTE, 1'b1, 1'b0);
        add_byte(ESCAPE_BYTE, 1'b0, 1'b1);  // pause the sender until the pad is out
        add_byte(8'h3C, 1'b1, 1'b0);
        add_escape(ESCAPE_BYTE, 8'hFF, 1'b0);
        add_byte(8'hAA, 1'b1, 1'b0);

        // Lower the target below what is already out: the image is full.
        write_pixel_target(16'd10);
        add_escape(8'h11, 8'h08, 1'b0);
        write_pixel_target(16'd5);
        add_byte(8'h22, 1'b1, 1'b0);

        while (queued_items < ITEM_GOAL) begin
            // swap the idle mix, then stop idling altogether
            if (idle_mode == 0 && queued_items >= 100) begin
                wait_feed_empty();
                send_idle_pct = 52;
                recv_idle_pct = 26;
                idle_mode     = 1;
            end else if (idle_mode == 1 && queued_items >= 175) begin
                wait_feed_empty();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                idle_mode     = 2;
            end
            if ($urandom_range(99) < 40)
                write_pixel_target(random_target());
            build_stream();
        end

        wait_quiet();
        $display("Sent %0d bytes in %0d streams with %0d target writes; %0d bytes ignored.",
                 bytes_sent, streams_done, cfg_writes, ignored_bytes);
        $display("Checked %0d runs, %0d of them zero pads; %0d mismatches.",
                 runs_checked, pad_runs, errors);
        if (errors == 0 && pending_runs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
